// File: rtl/sfe_pkg.sv
// Shared types and constants for the SBUS frame encoder.
package sfe_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int CHAN_W       = 4;
  localparam int VALUE_W      = 12;
  localparam int CODE_W       = 11;
  localparam int BYTE_W       = 8;
  localparam int PROD_W       = VALUE_W + CODE_W;
  localparam int BUF_W        = 18;
  localparam int CNT_W        = 5;
  localparam int REG_IDX_W    = 3;
  localparam int REG_DATA_W   = 12;
  localparam int STEP_W       = 4;

  localparam logic [REG_IDX_W-1:0] REG_IN_MIN      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_IN_MAX      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_OUT_MIN     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_OUT_MAX     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_HEADER_BYTE = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FOOTER_BYTE = 3'd5;

  localparam logic [VALUE_W-1:0] IN_MIN_RST      = 12'd1000;
  localparam logic [VALUE_W-1:0] IN_MAX_RST      = 12'd2000;
  localparam logic [CODE_W-1:0]  OUT_MIN_RST     = 11'd173;
  localparam logic [CODE_W-1:0]  OUT_MAX_RST     = 11'd1811;
  localparam logic [BYTE_W-1:0]  HEADER_BYTE_RST = 8'd15;
  localparam logic [BYTE_W-1:0]  FOOTER_BYTE_RST = 8'd0;
  localparam logic [BYTE_W-1:0]  FLAGS_BYTE      = 8'h00;

  localparam logic [CHAN_W-1:0] LAST_CHANNEL = CHAN_W'(NUM_CHANNELS - 1);

  typedef struct packed {
    logic [VALUE_W-1:0] in_min;
    logic [VALUE_W-1:0] in_max;
    logic [CODE_W-1:0]  out_min;
    logic [CODE_W-1:0]  out_max;
  } map_cfg_t;

  // Mapped channel code handed from the mapper to the packer.
  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
  } code_req_t;

endpackage

// File: rtl/sfe_mapper.sv
// Channel mapper: clamp, bit-serial multiply, restoring divide.
module sfe_mapper
  import sfe_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  map_cfg_t           cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [VALUE_W-1:0] channel_value,
  output code_req_t          code_req,
  input  logic               code_take
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CODE_W - 1);

  logic [1:0]         state;
  logic [STEP_W-1:0]  step;
  logic [VALUE_W-1:0] diff;
  logic [CODE_W-1:0]  mag;
  logic               neg;
  logic [PROD_W-1:0]  prod;
  logic [VALUE_W-1:0] rem;
  logic [CODE_W-1:0]  low;
  logic [CODE_W-1:0]  code;

  logic               span_empty;
  logic [VALUE_W-1:0] span;
  logic [VALUE_W-1:0] xc;
  logic [CODE_W-1:0]  delta;
  logic               accept;
  logic [PROD_W-1:0]  prod_next;
  logic [VALUE_W:0]   trial;
  logic               ge;
  logic [VALUE_W:0]   trial_sub;
  logic [CODE_W-1:0]  quot;

  assign span_empty = (cfg.in_max <= cfg.in_min);
  assign span       = cfg.in_max - cfg.in_min;
  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state != ST_IDLE);

  always_comb begin
    if (channel_value < cfg.in_min) begin
      xc = cfg.in_min;
    end else if (channel_value > cfg.in_max) begin
      xc = cfg.in_max;
    end else begin
      xc = channel_value;
    end
    if (cfg.out_max >= cfg.out_min) begin
      delta = cfg.out_max - cfg.out_min;
    end else begin
      delta = cfg.out_min - cfg.out_max;
    end
  end

  // Shift-add, multiplier bits taken MSB first.
  assign prod_next = {prod[PROD_W-2:0], 1'b0} +
                     (mag[CODE_W-1] ? PROD_W'(diff) : PROD_W'(0));

  // One quotient bit per cycle; rem always stays below span.
  assign trial     = {rem, low[CODE_W-1]};
  assign ge        = (trial >= {1'b0, span});
  assign trial_sub = trial - {1'b0, span};
  assign quot      = {low[CODE_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= span_empty ? ST_DONE : ST_MUL;
          end
        end
        ST_MUL: begin
          if (step == LAST_STEP) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (step == LAST_STEP) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (code_take) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        step <= '0;
        diff <= xc - cfg.in_min;
        mag  <= delta;
        neg  <= (cfg.out_max < cfg.out_min);
        prod <= '0;
        code <= cfg.out_min;
      end
      ST_MUL: begin
        prod <= prod_next;
        mag  <= {mag[CODE_W-2:0], 1'b0};
        if (step == LAST_STEP) begin
          step <= '0;
          rem  <= prod_next[PROD_W-1:CODE_W];
          low  <= prod_next[CODE_W-1:0];
        end else begin
          step <= step + 1'b1;
        end
      end
      ST_DIV: begin
        rem  <= ge ? trial_sub[VALUE_W-1:0] : trial[VALUE_W-1:0];
        low  <= quot;
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          code <= neg ? (cfg.out_min - quot) : (cfg.out_min + quot);
        end
      end
      default: begin
      end
    endcase
  end

  assign code_req.valid = (state == ST_DONE);
  assign code_req.code  = code;

endmodule

// File: rtl/sfe_packer.sv
// Byte packer: header, LSB-first channel bits, flags and footer.
module sfe_packer
  import sfe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [BYTE_W-1:0] header_byte,
  input  logic [BYTE_W-1:0] footer_byte,
  input  code_req_t         code_req,
  output logic              code_take,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte,
  output logic              run_last,
  output logic              frame_last
);

  logic [CHAN_W-1:0] channel_index;
  logic [BUF_W-1:0]  bit_buffer;
  logic [CNT_W-1:0]  bit_count;
  logic              hdr_pend;
  logic [1:0]        tail_pend;

  logic              data_ready;
  logic              busy;
  logic              load;
  logic [BUF_W-1:0]  merged;

  assign data_ready = (bit_count >= CNT_W'(BYTE_W));
  assign busy       = hdr_pend || data_ready || (tail_pend != 2'd0);
  assign code_take  = code_req.valid && !busy;
  assign load       = !out_valid || !out_stall;
  assign merged     = bit_buffer |
                      (BUF_W'(code_req.code) << bit_count[2:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_index <= '0;
      bit_buffer    <= '0;
      bit_count     <= '0;
      hdr_pend      <= 1'b0;
      tail_pend     <= 2'd0;
      out_valid     <= 1'b0;
    end else begin
      if (code_take) begin
        bit_buffer <= merged;
        bit_count  <= CNT_W'(bit_count[2:0]) + CNT_W'(CODE_W);
        hdr_pend   <= (channel_index == '0);
        tail_pend  <= (channel_index == LAST_CHANNEL) ? 2'd2 : 2'd0;
        channel_index <= (channel_index == LAST_CHANNEL) ? '0 : channel_index + 1'b1;
        // last byte of the previous request may leave on this edge
        if (load) begin
          out_valid <= 1'b0;
        end
      end else if (load) begin
        out_valid <= busy;
        if (hdr_pend) begin
          hdr_pend <= 1'b0;
        end else if (data_ready) begin
          bit_buffer <= bit_buffer >> BYTE_W;
          bit_count  <= bit_count - CNT_W'(BYTE_W);
        end else if (tail_pend == 2'd2) begin
          tail_pend <= 2'd1;
        end else if (tail_pend == 2'd1) begin
          tail_pend  <= 2'd0;
          bit_buffer <= '0;
          bit_count  <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!code_take && load) begin
      if (hdr_pend) begin
        out_byte   <= header_byte;
        run_last   <= 1'b0;
        frame_last <= 1'b0;
      end else if (data_ready) begin
        out_byte   <= bit_buffer[BYTE_W-1:0];
        run_last   <= (bit_count < CNT_W'(2 * BYTE_W)) && (tail_pend == 2'd0);
        frame_last <= 1'b0;
      end else if (tail_pend == 2'd2) begin
        out_byte   <= FLAGS_BYTE;
        run_last   <= 1'b0;
        frame_last <= 1'b0;
      end else begin
        out_byte   <= footer_byte;
        run_last   <= 1'b1;
        frame_last <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/sbus_frame_encoder.sv
// Top level of the SBUS frame encoder.
// Usage:
//   Input channel: channel_value with in_valid / in_stall. Send the sixteen
//   channel values of a frame in order, one request per channel.
//   Output channel: out_byte, run_last, frame_last with out_valid / out_stall.
//   A frame is 25 bytes: header, 22 packed data bytes, flags (zero), footer.
//   run_last marks the last byte of a request, frame_last the footer.
//   Config: cfg_write, cfg_index, cfg_data; write only while the block idles.
// Timing:
//   A channel whose input span is empty is mapped straight to out_min;
//   otherwise the mapper runs the shift-add multiply and then the restoring
//   divider, one bit per step each, and then hands the code to the packer.
//   Bytes then leave at one per cycle while out_stall is low. The mapper
//   takes the next request while the packer still sends the previous bytes.
//   Reset empties both stages, restarts at channel 0 and restores register
//   defaults. While out_stall is high the output byte holds; the packer and
//   then the mapper fill up and in_stall goes high.
module sbus_frame_encoder
  import sfe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [REG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_W-1:0]    channel_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BYTE_W-1:0]     out_byte,
  output logic                  run_last,
  output logic                  frame_last
);

  map_cfg_t          map_cfg;
  logic [BYTE_W-1:0] header_byte;
  logic [BYTE_W-1:0] footer_byte;
  code_req_t         code_req;
  logic              code_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_cfg.in_min  <= IN_MIN_RST;
      map_cfg.in_max  <= IN_MAX_RST;
      map_cfg.out_min <= OUT_MIN_RST;
      map_cfg.out_max <= OUT_MAX_RST;
      header_byte     <= HEADER_BYTE_RST;
      footer_byte     <= FOOTER_BYTE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IN_MIN:      map_cfg.in_min  <= cfg_data[VALUE_W-1:0];
        REG_IN_MAX:      map_cfg.in_max  <= cfg_data[VALUE_W-1:0];
        REG_OUT_MIN:     map_cfg.out_min <= cfg_data[CODE_W-1:0];
        REG_OUT_MAX:     map_cfg.out_max <= cfg_data[CODE_W-1:0];
        REG_HEADER_BYTE: header_byte     <= cfg_data[BYTE_W-1:0];
        REG_FOOTER_BYTE: footer_byte     <= cfg_data[BYTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sfe_mapper u_mapper (
    .clk           (clk),
    .rst           (rst),
    .cfg           (map_cfg),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .channel_value (channel_value),
    .code_req      (code_req),
    .code_take     (code_take)
  );

  sfe_packer u_packer (
    .clk         (clk),
    .rst         (rst),
    .header_byte (header_byte),
    .footer_byte (footer_byte),
    .code_req    (code_req),
    .code_take   (code_take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .frame_last  (frame_last)
  );

endmodule

// File: rtl/sfe_checker.sv
// Port-level checks for the SBUS frame encoder, bound to the top level.
module sfe_checker
  import sfe_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [BYTE_W-1:0] out_byte,
  input logic              run_last,
  input logic              frame_last
);

  // The footer always closes the request that carries it.
  a_frame_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> run_last)
    else $error("frame_last without run_last");

  // One request at a time: the mapper is busy right after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted on consecutive cycles");

  a_reset_empties: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
      $stable(run_last) && $stable(frame_last))
    else $error("stalled output changed");

endmodule

bind sbus_frame_encoder sfe_checker u_sfe_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_byte   (out_byte),
  .run_last   (run_last),
  .frame_last (frame_last)
);

// File: tb/tb_top.sv
// Self-checking testbench for the SBUS frame encoder: channel requests in, frame bytes out.
module tb_top;
  import sfe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_AT     = 180;   // bytes taken before the long output hold
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 40;
  localparam int DIR_ROWS    = 31;

  // Indexes past the last register; the block must ignore writes to them.
  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum logic {ROW_CHANNEL, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [REG_IDX_W-1:0]  idx;
    logic [REG_DATA_W-1:0] val;
    logic                  typed;
    logic [CODE_W-1:0]     code;
  } step_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              run_end;
    logic              frame_end;
  } sbus_byte_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [REG_IDX_W-1:0]  cfg_index = '0;
  logic [REG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [VALUE_W-1:0]    channel_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [BYTE_W-1:0]     out_byte;
  logic                  run_last;
  logic                  frame_last;

  sbus_frame_encoder uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .channel_value (channel_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .run_last      (run_last),
    .frame_last    (frame_last)
  );

  always #6 clk = ~clk;

  // Register copies and packer state of the encoder as the testbench sees it
  logic [VALUE_W-1:0] cfg_in_min  = IN_MIN_RST;
  logic [VALUE_W-1:0] cfg_in_max  = IN_MAX_RST;
  logic [CODE_W-1:0]  cfg_out_min = OUT_MIN_RST;
  logic [CODE_W-1:0]  cfg_out_max = OUT_MAX_RST;
  logic [BYTE_W-1:0]  cfg_header  = HEADER_BYTE_RST;
  logic [BYTE_W-1:0]  cfg_footer  = FOOTER_BYTE_RST;
  logic [CHAN_W-1:0]  chan_idx    = '0;
  logic [BUF_W-1:0]   pend_bits   = '0;
  logic [CNT_W-1:0]   pend_cnt    = '0;

  sbus_byte_t bytes_due[$];
  sbus_byte_t want;
  int         mismatches  = 0;
  int         bytes_taken = 0;
  int         burst_left  = 0;
  int         cycle_cnt   = 0;

  step_t plan [DIR_ROWS] = '{
    '{ROW_CHANNEL, REG_IN_MIN,      12'd0,    1'b1, 11'd173},
    '{ROW_CHANNEL, REG_IN_MIN,      12'd4095, 1'b1, 11'd1811},
    '{ROW_CHANNEL, REG_IN_MIN,      12'd1000, 1'b1, 11'd173},
    '{ROW_CHANNEL, REG_IN_MIN,      12'd2000, 1'b1, 11'd1811},
    '{ROW_CHANNEL, REG_IN_MIN,      12'd1500, 1'b0, 11'd0},
    '{ROW_CHANNEL, REG_IN_MIN,      12'd999,  1'b1, 11'd173},
    // full span, falling output
    '{ROW_REG,     REG_IN_MIN,      12'd0,    1'b0, 11'd0},
    '{ROW_REG,     REG_IN_MAX,      12'd4095, 1'b0, 11'd0},
    '{ROW_REG,     REG_OUT_MIN,     12'd2047, 1'b0, 11'd0},
    '{ROW_REG,     REG_OUT_MAX,     12'd0,    1'b0, 11'd0},
    '{ROW_CHANNEL, REG_IN_MIN,      12'd0,    1'b1, 11'd2047},
    '{ROW_CHANNEL, REG_IN_MIN,      12'd4095, 1'b1, 11'd0},
    '{ROW_CHANNEL, REG_IN_MIN,      12'd2048, 1'b0, 11'd0},
    '{ROW_CHANNEL, REG_IN_MIN,      12'd1,    1'b0, 11'd0},
    // inverted, then equal input span: everything encodes as out_min
    '{ROW_REG,     REG_IN_MIN,      12'd4095, 1'b0, 11'd0},
    '{ROW_REG,     REG_IN_MAX,      12'd0,    1'b0, 11'd0},
    '{ROW_CHANNEL, REG_IN_MIN,      12'd0,    1'b1, 11'd2047},
    '{ROW_CHANNEL, REG_IN_MIN,      12'd4095, 1'b1, 11'd2047},
    '{ROW_REG,     REG_IN_MAX,      12'd4095, 1'b0, 11'd0},
    '{ROW_CHANNEL, REG_IN_MIN,      12'd2730, 1'b1, 11'd2047},
    // rising full span; out_min data is masked to 11 bits, footer to 8
    '{ROW_REG,     REG_IN_MIN,      12'd0,    1'b0, 11'd0},
    '{ROW_REG,     REG_OUT_MIN,     12'h800,  1'b0, 11'd0},
    '{ROW_REG,     REG_OUT_MAX,     12'd2047, 1'b0, 11'd0},
    '{ROW_REG,     REG_HEADER_BYTE, 12'd255,  1'b0, 11'd0},
    '{ROW_REG,     REG_FOOTER_BYTE, 12'hFFF,  1'b0, 11'd0},
    '{ROW_REG,     REG_SPARE_HI,    12'hABC,  1'b0, 11'd0},
    '{ROW_CHANNEL, REG_IN_MIN,      12'd4095, 1'b1, 11'd2047},
    '{ROW_CHANNEL, REG_IN_MIN,      12'd0,    1'b1, 11'd0},
    '{ROW_CHANNEL, REG_IN_MIN,      12'd2457, 1'b0, 11'd0},  // channel 15: flags + footer
    '{ROW_CHANNEL, REG_IN_MIN,      12'd1234, 1'b0, 11'd0},  // new frame header
    '{ROW_REG,     REG_SPARE_LO,    12'h555,  1'b0, 11'd0}
  };

  function automatic logic [CODE_W-1:0] scale_channel(input logic [VALUE_W-1:0] raw);
    int x;
    int q;
    if (cfg_in_max <= cfg_in_min) return cfg_out_min;
    x = int'(raw);
    if (x < int'(cfg_in_min)) x = int'(cfg_in_min);
    if (x > int'(cfg_in_max)) x = int'(cfg_in_max);
    // int division truncates toward zero, as a falling span needs
    q = ((x - int'(cfg_in_min)) * (int'(cfg_out_max) - int'(cfg_out_min)))
        / (int'(cfg_in_max) - int'(cfg_in_min)) + int'(cfg_out_min);
    return q[CODE_W-1:0];
  endfunction

  function automatic void encode_channel(input logic [CODE_W-1:0] code);
    if (chan_idx == '0) bytes_due.push_back('{cfg_header, 1'b0, 1'b0});
    pend_bits = pend_bits | (BUF_W'(code) << pend_cnt[2:0]);
    pend_cnt  = CNT_W'(pend_cnt[2:0]) + CNT_W'(CODE_W);
    while (pend_cnt >= 8) begin
      bytes_due.push_back('{pend_bits[7:0], (pend_cnt < 16) && (chan_idx != LAST_CHANNEL),
                            1'b0});
      pend_bits = pend_bits >> 8;
      pend_cnt  = pend_cnt - 5'd8;
    end
    if (chan_idx == LAST_CHANNEL) begin
      bytes_due.push_back('{FLAGS_BYTE, 1'b0, 1'b0});
      bytes_due.push_back('{cfg_footer, 1'b1, 1'b1});
      pend_bits = '0;
      pend_cnt  = '0;
      chan_idx  = '0;
    end else begin
      chan_idx = chan_idx + 1'b1;
    end
  endfunction

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= REG_DATA_W'(data);
    @(posedge clk);
    case (idx)
      REG_IN_MIN:      cfg_in_min  = VALUE_W'(data);
      REG_IN_MAX:      cfg_in_max  = VALUE_W'(data);
      REG_OUT_MIN:     cfg_out_min = CODE_W'(data);
      REG_OUT_MAX:     cfg_out_max = CODE_W'(data);
      REG_HEADER_BYTE: cfg_header  = BYTE_W'(data);
      REG_FOOTER_BYTE: cfg_footer  = BYTE_W'(data);
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk);
  endtask

  task automatic send_channel(input logic [VALUE_W-1:0] value, input logic typed,
                              input logic [CODE_W-1:0] typed_code);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    channel_value <= value;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    encode_channel(typed ? typed_code : scale_channel(value));
  endtask

  // Output side: byte check plus the stall pattern
  int stall_pct = 0;
  int pat_left  = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (bytes_due.size() == 0) begin
          $display("%0t: unexpected byte data=%h run_last=%b frame_last=%b",
                   $time, out_byte, run_last, frame_last);
          mismatches++;
        end else begin
          want = bytes_due.pop_front();
          if (out_byte !== want.data || run_last !== want.run_end ||
              frame_last !== want.frame_end) begin
            $display("%0t: byte %0d expected data=%h run_last=%b frame_last=%b,",
                     $time, bytes_taken, want.data, want.run_end, want.frame_end,
                     " got data=%h run_last=%b frame_last=%b",
                     out_byte, run_last, frame_last);
            mismatches++;
          end
        end
        bytes_taken++;
      end
      // one long hold so the block backs up into its input
      if (bytes_taken == HOLD_AT && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (pat_left == 0) begin
          pat_left = 40;
          case ($urandom_range(0, 4))
            0, 1: stall_pct = 0;
            2: stall_pct = 20;
            3: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        pat_left--;
        out_stall <= ($urandom_range(1, 100) <= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int   phase;
    int   k;
    int   lo;
    int   hi;
    int   r;
    int   v;
    logic in_cfg;
    in_cfg = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (k = 0; k < DIR_ROWS; k++) begin
      if (plan[k].kind == ROW_REG) begin
        if (!in_cfg) wait_idle();
        in_cfg = 1'b1;
        write_reg(plan[k].idx, int'(plan[k].val));
      end else begin
        if (in_cfg) cfg_write <= 1'b0;
        in_cfg = 1'b0;
        send_channel(plan[k].val, plan[k].typed, plan[k].code);
      end
    end
    cfg_write <= 1'b0;

    for (phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      // span flavor rotates: random, full, empty or inverted, one step wide
      case (phase % 4)
        0: begin
          lo = $urandom_range(0, 3000);
          hi = $urandom_range(lo + 1, 4095);
        end
        1: begin
          lo = 0;
          hi = 4095;
        end
        2: begin
          hi = $urandom_range(0, 4095);
          lo = $urandom_range(hi, 4095);
        end
        default: begin
          lo = $urandom_range(0, 4094);
          hi = lo + 1;
        end
      endcase
      write_reg(REG_IN_MIN, lo);
      write_reg(REG_IN_MAX, hi);
      if (phase % 4 == 1) begin
        write_reg(REG_OUT_MIN, (phase < 4) ? 0 : 2047);
        write_reg(REG_OUT_MAX, (phase < 4) ? 2047 : 0);
      end else begin
        write_reg(REG_OUT_MIN, $urandom_range(0, 4095));
        write_reg(REG_OUT_MAX, $urandom_range(0, 4095));
      end
      write_reg(REG_HEADER_BYTE, $urandom_range(0, 4095));
      write_reg(REG_FOOTER_BYTE, $urandom_range(0, 4095));
      write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom_range(0, 4095));
      cfg_write <= 1'b0;

      for (k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 9);
        if (r < 7 && lo <= hi) v = $urandom_range(lo, hi);
        else if (r == 7) v = $urandom_range(0, 1) ? 4095 : 0;
        else if (r == 8) v = $urandom_range(0, 1) ? hi + 1 : lo - 1;
        else v = $urandom_range(0, 4095);
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        send_channel(VALUE_W'(v), 1'b0, '0);
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
